[rtl/core/plvg_pkg.sv]
// ----------------------------------------------------------------------------
// plvg_pkg
// Shared types, register indexes and exp2 constants for the levels/gamma unit.
// ----------------------------------------------------------------------------
package plvg_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int FRAC       = 30;
	localparam int LOG_STEPS  = 30;
	localparam int EXP_STEPS  = 30;

	localparam logic [PIXEL_BITS-1:0] FULL_SCALE = 16'hFFFF;

	// configuration register indexes
	localparam logic [2:0] REG_IN_BLACK  = 3'd0;
	localparam logic [2:0] REG_IN_WHITE  = 3'd1;
	localparam logic [2:0] REG_INV_GAMMA = 3'd2;
	localparam logic [2:0] REG_OUT_BLACK = 3'd3;
	localparam logic [2:0] REG_OUT_WHITE = 3'd4;

	// which level an item resolves to
	typedef enum logic [1:0] {
		SEL_BLACK = 2'd0,
		SEL_WHITE = 2'd1,
		SEL_BAND  = 2'd2
	} sel_t;

	// c_0 = 2.0, c_i = floor(sqrt(c_(i-1) * 2^30)), all Q.30
	function automatic logic [31:0] exp_const(input int idx);
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] root;
		logic [63:0] bt;
		int j;
		int s;
		c = 64'd1 << 31;
		for (j = 1; j <= idx; j++) begin
			v = c << 30;
			root = 64'd0;
			bt = 64'd1 << 62;
			for (s = 0; s < 32; s++) begin
				if (v >= root + bt) begin
					v = v - (root + bt);
					root = (root >> 1) + bt;
				end else begin
					root = root >> 1;
				end
				bt = bt >> 2;
			end
			c = root;
		end
		return c[31:0];
	endfunction

endpackage

[rtl/core/pixel_levels_gamma_adjust_unit.sv]
// ----------------------------------------------------------------------------
// pixel_levels_gamma_adjust_unit
// Levels adjustment with gamma for one 16-bit pixel channel.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream (one 16-bit channel value each) and leave on
//   the m_ stream (one 16-bit adjusted value each), in order, one for one.
//   Levels and inverse gamma are written on the cfg_ channel (index 0..4:
//   in_black, in_white, inv_gamma, out_black, out_white); cfg_ready is always
//   high and writes are expected only while no item is in flight.
//   Throughput: one item per clock while m_tready does not stall the pipeline.
//   The pipeline depth is set mainly by the two 30-step chains (log2
//   square-and-compare and exp2 constant products), each step one register stage.
//   Reset clears all stage valid bits and loads the default levels
//   (0, 65535, gamma 1.0, 0, 65535); no item is held.
//   When the receiver holds m_tready low with a result waiting, the whole
//   pipeline freezes and s_tready falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pixel_levels_gamma_adjust_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] pixel_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] pixel_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import plvg_pkg::*;

	logic        en;
	logic [15:0] in_black_q, in_white_q, inv_gamma_q, out_black_q, out_white_q;

	// stage 1: range check
	logic        vld_s1;
	sel_t        sel_s1;
	logic [15:0] n_s1, d_s1;
	sel_t        sel_c;

	// stage 2: log2 normalize
	logic        vld_s2;
	sel_t        sel_s2;
	logic [3:0]  en_s2, ed_s2;
	logic [30:0] mn_s2, md_s2;
	logic [3:0]  e_n_c, e_d_c;

	// log chain side data
	logic        log_vld_s [0:LOG_STEPS];
	sel_t        log_sel_s [0:LOG_STEPS];
	logic [3:0]  log_en_s  [0:LOG_STEPS];
	logic [3:0]  log_ed_s  [0:LOG_STEPS];
	logic [30:0] log_mn    [0:LOG_STEPS];
	logic [30:0] log_md    [0:LOG_STEPS];
	logic [29:0] log_fn    [0:LOG_STEPS];
	logic [29:0] log_fd    [0:LOG_STEPS];

	// exponent stages
	logic        vld_s3, vld_s4, vld_s5;
	sel_t        sel_s3, sel_s4;
	logic [33:0] neg_s3;
	logic [41:0] y_s4;
	logic [33:0] ln_c, ld_c;
	logic [50:0] ymul_c;
	logic [11:0] k_c;

	// exp chain side data
	logic        exp_vld_s   [0:EXP_STEPS];
	sel_t        exp_sel_s   [0:EXP_STEPS];
	logic [4:0]  exp_k_s     [0:EXP_STEPS];
	logic        exp_big_s   [0:EXP_STEPS];
	logic        exp_exact_s [0:EXP_STEPS];
	logic [30:0] exp_p       [0:EXP_STEPS];
	logic [29:0] exp_u       [0:EXP_STEPS];

	// tail
	logic        vld_s6, vld_s7, vld_s8;
	sel_t        sel_s6, sel_s7;
	logic [30:0] r_s6;
	logic signed [48:0] prod_s7;
	logic [15:0] out_s8;
	logic [30:0] r_c;
	logic signed [16:0] diff_c;
	logic signed [50:0] total_c;
	logic [15:0] band_c;

	assign en        = !vld_s8 || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_s8;
	assign m_tdata   = out_s8;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_black_q  <= 16'd0;
			in_white_q  <= FULL_SCALE;
			inv_gamma_q <= 16'd256;
			out_black_q <= 16'd0;
			out_white_q <= FULL_SCALE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IN_BLACK:  in_black_q  <= cfg_data;
				REG_IN_WHITE:  in_white_q  <= cfg_data;
				REG_INV_GAMMA: inv_gamma_q <= cfg_data;
				REG_OUT_BLACK: out_black_q <= cfg_data;
				REG_OUT_WHITE: out_white_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [3:0] msb_pos(input logic [15:0] v);
		logic [3:0] p;
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) p = 4'(i);
		end
		return p;
	endfunction

	// ---------------- stage 1 ----------------
	always_comb begin
		priority if (s_tdata <= in_black_q) sel_c = SEL_BLACK;
		else if (s_tdata >= in_white_q)     sel_c = SEL_WHITE;
		else                                sel_c = SEL_BAND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= sel_c;
			n_s1   <= s_tdata - in_black_q;
			d_s1   <= in_white_q - in_black_q;
		end
	end

	// ---------------- stage 2 ----------------
	assign e_n_c = msb_pos(n_s1);
	assign e_d_c = msb_pos(d_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2 <= sel_s1;
			en_s2  <= e_n_c;
			ed_s2  <= e_d_c;
			mn_s2  <= 31'(n_s1) << (5'd30 - {1'b0, e_n_c});
			md_s2  <= 31'(d_s1) << (5'd30 - {1'b0, e_d_c});
		end
	end

	// ---------------- log2 chain ----------------
	assign log_vld_s[0] = vld_s2;
	assign log_sel_s[0] = sel_s2;
	assign log_en_s[0]  = en_s2;
	assign log_ed_s[0]  = ed_s2;
	assign log_mn[0]    = mn_s2;
	assign log_md[0]    = md_s2;
	assign log_fn[0]    = 30'd0;
	assign log_fd[0]    = 30'd0;

	for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
		plvg_log2_stage #(.BIT(LOG_STEPS - 1 - i)) u_log_n (
			.clk      (clk),
			.en       (en),
			.m_in     (log_mn[i]),
			.frac_in  (log_fn[i]),
			.m_out    (log_mn[i+1]),
			.frac_out (log_fn[i+1])
		);
		plvg_log2_stage #(.BIT(LOG_STEPS - 1 - i)) u_log_d (
			.clk      (clk),
			.en       (en),
			.m_in     (log_md[i]),
			.frac_in  (log_fd[i]),
			.m_out    (log_md[i+1]),
			.frac_out (log_fd[i+1])
		);

		logic vld_q;
		sel_t sel_q;
		logic [3:0] en_q, ed_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else if (en) begin
				vld_q <= log_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sel_q <= log_sel_s[i];
				en_q  <= log_en_s[i];
				ed_q  <= log_ed_s[i];
			end
		end

		assign log_vld_s[i+1] = vld_q;
		assign log_sel_s[i+1] = sel_q;
		assign log_en_s[i+1]  = en_q;
		assign log_ed_s[i+1]  = ed_q;
	end

	// ---------------- stage 3: log difference ----------------
	assign ln_c = {log_en_s[LOG_STEPS], log_fn[LOG_STEPS]};
	assign ld_c = {log_ed_s[LOG_STEPS], log_fd[LOG_STEPS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3 <= log_vld_s[LOG_STEPS];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s3 <= log_sel_s[LOG_STEPS];
			neg_s3 <= (ld_c > ln_c) ? (ld_c - ln_c) : 34'd0;
		end
	end

	// ---------------- stage 4: scale by inverse gamma, round at Q.30 ----------------
	assign ymul_c = 51'(neg_s3) * 51'(inv_gamma_q) + 51'd128;

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s4 <= sel_s3;
			y_s4   <= ymul_c[49:8];
		end
	end

	// ---------------- stage 5: split exponent ----------------
	assign k_c = y_s4[41:30];

	logic exp_vld_q;
	sel_t exp_sel_q;
	logic [4:0] exp_k_q;
	logic exp_big_q, exp_exact_q;
	logic [29:0] exp_u_q;

	always_ff @(posedge clk) begin
		if (en) begin
			exp_sel_q   <= sel_s4;
			exp_k_q     <= k_c[4:0];
			exp_big_q   <= (k_c >= 12'd17);
			exp_exact_q <= (y_s4[29:0] == 30'd0);
			exp_u_q     <= 30'd0 - y_s4[29:0];
		end
	end

	assign exp_vld_q      = vld_s5;
	assign exp_vld_s[0]   = exp_vld_q;
	assign exp_sel_s[0]   = exp_sel_q;
	assign exp_k_s[0]     = exp_k_q;
	assign exp_big_s[0]   = exp_big_q;
	assign exp_exact_s[0] = exp_exact_q;
	assign exp_u[0]       = exp_u_q;
	assign exp_p[0]       = 31'h4000_0000;

	// ---------------- exp2 chain ----------------
	for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
		plvg_exp2_stage #(.BIT(EXP_STEPS - 1 - i)) u_exp (
			.clk   (clk),
			.en    (en),
			.p_in  (exp_p[i]),
			.u_in  (exp_u[i]),
			.p_out (exp_p[i+1]),
			.u_out (exp_u[i+1])
		);

		logic vld_q;
		sel_t sel_q;
		logic [4:0] k_q;
		logic big_q, exact_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else if (en) begin
				vld_q <= exp_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sel_q   <= exp_sel_s[i];
				k_q     <= exp_k_s[i];
				big_q   <= exp_big_s[i];
				exact_q <= exp_exact_s[i];
			end
		end

		assign exp_vld_s[i+1]   = vld_q;
		assign exp_sel_s[i+1]   = sel_q;
		assign exp_k_s[i+1]     = k_q;
		assign exp_big_s[i+1]   = big_q;
		assign exp_exact_s[i+1] = exact_q;
	end

	// ---------------- stage 6: ratio ----------------
	always_comb begin
		priority if (exp_big_s[EXP_STEPS]) r_c = 31'd0;
		else if (exp_exact_s[EXP_STEPS])  r_c = 31'h4000_0000 >> exp_k_s[EXP_STEPS];
		else r_c = exp_p[EXP_STEPS] >> ({1'b0, exp_k_s[EXP_STEPS]} + 6'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s6 <= exp_vld_s[EXP_STEPS];
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s6 <= exp_sel_s[EXP_STEPS];
			r_s6   <= r_c;
		end
	end

	// ---------------- stage 7: scale by output span ----------------
	assign diff_c = $signed({1'b0, out_white_q}) - $signed({1'b0, out_black_q});

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s7  <= sel_s6;
			prod_s7 <= 49'(diff_c) * 49'($signed({1'b0, r_s6}));
		end
	end

	// ---------------- stage 8: offset, round, clamp ----------------
	assign total_c = $signed({5'd0, out_black_q, 30'd0}) + 51'(prod_s7)
		+ $signed(51'h2000_0000);

	always_comb begin
		priority if (total_c[50])              band_c = 16'd0;
		else if (|total_c[49:46])              band_c = FULL_SCALE;
		else                                   band_c = total_c[45:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (sel_s7)
				SEL_BLACK: out_s8 <= out_black_q;
				SEL_WHITE: out_s8 <= out_white_q;
				SEL_BAND:  out_s8 <= band_c;
				default:   out_s8 <= band_c;
			endcase
		end
	end

endmodule

[rtl/core/plvg_log2_stage.sv]
// ----------------------------------------------------------------------------
// plvg_log2_stage
// One square-and-compare step of the fixed-point log2, producing one bit.
// ----------------------------------------------------------------------------
module plvg_log2_stage #(
	parameter int BIT = 29
) (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] m_in,
	input  logic [29:0] frac_in,
	output logic [30:0] m_out,
	output logic [29:0] frac_out
);
	import plvg_pkg::*;

	logic [61:0] sq;
	logic [31:0] t;
	logic [30:0] m_q;
	logic [29:0] frac_q;

	assign sq = 62'(m_in) * 62'(m_in);
	assign t  = sq[61:30];

	// mantissa reached 2.0: halve it and set this fraction bit
	always_ff @(posedge clk) begin
		if (en) begin
			m_q    <= t[31] ? t[31:1] : t[30:0];
			frac_q <= t[31] ? (frac_in | (30'd1 << BIT)) : frac_in;
		end
	end

	assign m_out    = m_q;
	assign frac_out = frac_q;

endmodule

[rtl/core/plvg_exp2_stage.sv]
// ----------------------------------------------------------------------------
// plvg_exp2_stage
// One step of the fixed-point exp2: multiply by a root-of-two constant when this step's bit is set.
// ----------------------------------------------------------------------------
module plvg_exp2_stage #(
	parameter int BIT = 29
) (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] p_in,
	input  logic [29:0] u_in,
	output logic [30:0] p_out,
	output logic [29:0] u_out
);
	import plvg_pkg::*;

	localparam logic [31:0] C_FULL = exp_const(FRAC - BIT);
	localparam logic [30:0] C      = C_FULL[30:0];

	logic [61:0] prod;
	logic [30:0] p_q;
	logic [29:0] u_q;

	assign prod = 62'(p_in) * 62'(C);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= u_in[BIT] ? prod[60:30] : p_in;
			u_q <= u_in;
		end
	end

	assign p_out = p_q;
	assign u_out = u_q;

endmodule
